// ===== rtl/core/skyline_atlas_allocator_assert.svh =====
// Assertion macros for the skyline atlas allocator top level
`ifndef SKYLINE_ATLAS_ALLOCATOR_ASSERT_SVH
`define SKYLINE_ATLAS_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, ignored while rst_ni is low
`define SAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, ignored while rst_ni is low
`define SAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sal_pkg.sv =====
// Package with sizes, types and codes of the skyline atlas allocator
`timescale 1ns / 1ps
package sal_pkg;

  localparam int unsigned PAGE_WIDTH  = 128;
  localparam int unsigned PAGE_HEIGHT = 128;
  localparam int unsigned PAGE_COUNT  = 64;

  localparam int unsigned COL_W  = (PAGE_WIDTH > 1) ? $clog2(PAGE_WIDTH) : 1;
  localparam int unsigned PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned FILL_W = $clog2(PAGE_HEIGHT + 1);

  localparam int unsigned REQ_TYPE_W = 1;
  localparam int unsigned RECT_W     = 8;
  localparam int unsigned STATUS_W   = 1;
  localparam int unsigned PAGE_OUT_W = 6;
  localparam int unsigned XPOS_W     = 7;
  localparam int unsigned YPOS_W     = 7;

  localparam int unsigned CMP_W = (COL_W + 1 > RECT_W) ? COL_W + 1 : RECT_W;
  localparam int unsigned SUM_W = ((FILL_W > RECT_W) ? FILL_W : RECT_W) + 1;

  localparam int unsigned IN_TDATA_W  = ((2 * RECT_W + 7) / 8) * 8;
  localparam int unsigned OUT_BITS    = PAGE_OUT_W + XPOS_W + YPOS_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 1'b0;
  localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 1'b0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_PLACED,
    RES_FULL
  } res_kind_e;

  typedef struct packed {
    logic      load_req;
    logic      page_rst;
    logic      page_inc;
    logic      col_set_hi;
    logic      col_rst;
    logic      back_issue;
    logic      fwd_issue;
    logic      fwd_init;
    logic      wr_init;
    logic      wr_step;
    logic      clr_step;
    logic      res_load;
    res_kind_e res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic w_zero;
    logic w_wide;
    logic col_zero;
    logic col_top;
    logic page_last;
    logic wr_last;
    logic fits;
  } dp_sts_t;

endpackage

// ===== rtl/core/sal_dpath.sv =====
// Datapath: column fill memory, block suffix buffer, window search and result
`timescale 1ns / 1ps
module sal_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sal_pkg::dp_cmd_t                    cmd_i,
  output sal_pkg::dp_sts_t                    sts_o,
  input  logic [sal_pkg::RECT_W-1:0]          req_width_i,
  input  logic [sal_pkg::RECT_W-1:0]          req_height_i,
  output logic [sal_pkg::STATUS_W-1:0]        res_status_o,
  output logic [sal_pkg::PAGE_OUT_W-1:0]      res_page_o,
  output logic [sal_pkg::XPOS_W-1:0]          res_x_o,
  output logic [sal_pkg::YPOS_W-1:0]          res_y_o
);
  import sal_pkg::*;

  localparam int unsigned MEM_DEPTH = 1 << (PAGE_W + COL_W);

  typedef struct packed {
    logic              start;
    logic [FILL_W-1:0] val;
  } sfx_t;

  function automatic logic [FILL_W-1:0] fmax(input logic [FILL_W-1:0] a,
                                             input logic [FILL_W-1:0] b);
    fmax = (a > b) ? a : b;
  endfunction

  logic [FILL_W-1:0] fill_mem [MEM_DEPTH];
  sfx_t              sfx_mem  [PAGE_WIDTH];

  logic [COL_W-1:0]  col_q, col_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [RECT_W-1:0] w_q, h_q, cnt_q, blk_q;
  logic [FILL_W-1:0] best_q, run_q, pre_q, rd_q;
  logic [COL_W-1:0]  bx_q, tag_q;
  logic              found_q, iss_b_q, iss_f_q;
  sfx_t              sfx_a_q, sfx_b_q;

  logic [PAGE_W+COL_W-1:0] fill_addr;
  logic                    fill_we;
  logic [FILL_W-1:0]       fill_wdata;
  logic [COL_W-1:0]        sfx_b_addr;
  logic                    b_first, f_first, f_full, f_better;
  logic [FILL_W-1:0]       run_new, pre_new, win_max;
  logic [RECT_W-1:0]       blk_new;
  sfx_t                    sfx_wdata;
  logic [COL_W-1:0]        bx_new;
  logic [SUM_W-1:0]        top_sum;
  logic                    col_top, page_last;

  assign col_top   = (col_q == COL_W'(PAGE_WIDTH - 1));
  assign page_last = (page_q == PAGE_W'(PAGE_COUNT - 1));
  assign top_sum   = SUM_W'(best_q) + SUM_W'(h_q);

  assign sts_o.w_zero    = (w_q == '0);
  assign sts_o.w_wide    = (CMP_W'(w_q) > CMP_W'(PAGE_WIDTH));
  assign sts_o.col_zero  = (col_q == '0);
  assign sts_o.col_top   = col_top;
  assign sts_o.page_last = page_last;
  assign sts_o.wr_last   = (cnt_q == (w_q - RECT_W'(1)));
  assign sts_o.fits      = found_q && (top_sum <= SUM_W'(PAGE_HEIGHT));

  always_comb begin
    col_d = col_q;
    if (cmd_i.col_set_hi) begin
      col_d = COL_W'(PAGE_WIDTH - 1);
    end else if (cmd_i.col_rst) begin
      col_d = '0;
    end else if (cmd_i.back_issue) begin
      col_d = col_q - COL_W'(1);
    end else if (cmd_i.fwd_issue || cmd_i.wr_step) begin
      col_d = col_q + COL_W'(1);
    end else if (cmd_i.wr_init) begin
      col_d = bx_q;
    end else if (cmd_i.clr_step) begin
      col_d = col_top ? '0 : col_q + COL_W'(1);
    end
  end

  always_comb begin
    page_d = page_q;
    if (cmd_i.page_rst) begin
      page_d = '0;
    end else if (cmd_i.page_inc) begin
      page_d = page_q + PAGE_W'(1);
    end else if (cmd_i.clr_step && col_top) begin
      page_d = page_last ? '0 : page_q + PAGE_W'(1);
    end
  end

  assign fill_addr  = {page_q, col_q};
  assign fill_we    = cmd_i.clr_step || cmd_i.wr_step;
  assign fill_wdata = cmd_i.clr_step ? '0 : FILL_W'(top_sum);
  assign sfx_b_addr = COL_W'(CMP_W'(col_q) + CMP_W'(1) - CMP_W'(w_q));

  // backward pass: running max inside blocks of w columns aligned to the right edge
  assign b_first       = (tag_q == COL_W'(PAGE_WIDTH - 1)) || (blk_q == w_q);
  assign run_new       = b_first ? rd_q : fmax(run_q, rd_q);
  assign blk_new       = b_first ? RECT_W'(1) : blk_q + RECT_W'(1);
  assign sfx_wdata.start = (blk_new == w_q);
  assign sfx_wdata.val   = run_new;

  // forward pass: prefix max per block, window max from suffix and prefix
  assign f_first  = (tag_q == '0) || sfx_a_q.start;
  assign pre_new  = f_first ? rd_q : fmax(pre_q, rd_q);
  assign f_full   = (CMP_W'(tag_q) + CMP_W'(1)) >= CMP_W'(w_q);
  assign win_max  = fmax(sfx_b_q.val, pre_new);
  assign f_better = iss_f_q && f_full && (win_max < best_q);
  assign bx_new   = COL_W'(CMP_W'(tag_q) + CMP_W'(1) - CMP_W'(w_q));

  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_mem[fill_addr] <= fill_wdata;
    end
    rd_q <= fill_mem[fill_addr];
  end

  always_ff @(posedge clk_i) begin
    if (iss_b_q) begin
      sfx_mem[tag_q] <= sfx_wdata;
    end
    sfx_a_q <= sfx_mem[col_q];
    sfx_b_q <= sfx_mem[sfx_b_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      page_q  <= '0;
      iss_b_q <= 1'b0;
      iss_f_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      page_q  <= page_d;
      iss_b_q <= cmd_i.back_issue;
      iss_f_q <= cmd_i.fwd_issue;
      if (cmd_i.fwd_init) begin
        found_q <= 1'b0;
      end else if (f_better) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= col_q;
    if (cmd_i.load_req) begin
      w_q <= req_width_i;
      h_q <= req_height_i;
    end
    if (iss_b_q) begin
      run_q <= run_new;
      blk_q <= blk_new;
    end
    if (iss_f_q) begin
      pre_q <= pre_new;
    end
    if (cmd_i.fwd_init) begin
      best_q <= FILL_W'(PAGE_HEIGHT);
    end else if (f_better) begin
      best_q <= win_max;
      bx_q   <= bx_new;
    end
    if (cmd_i.wr_init) begin
      cnt_q <= '0;
    end else if (cmd_i.wr_step) begin
      cnt_q <= cnt_q + RECT_W'(1);
    end
    if (cmd_i.res_load) begin
      case (cmd_i.res_kind)
        RES_PLACED: begin
          res_status_o <= STATUS_OK;
          res_page_o   <= PAGE_OUT_W'(page_q);
          res_x_o      <= XPOS_W'(bx_q);
          res_y_o      <= YPOS_W'(best_q);
        end
        RES_FULL: begin
          res_status_o <= STATUS_FULL;
          res_page_o   <= '0;
          res_x_o      <= '0;
          res_y_o      <= '0;
        end
        default: begin
          res_status_o <= STATUS_OK;
          res_page_o   <= '0;
          res_x_o      <= '0;
          res_y_o      <= '0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/sal_ctrl.sv =====
// Controller: sequences clearing, page scans, column updates and result hand-off
`timescale 1ns / 1ps
module sal_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sal_pkg::REQ_TYPE_W-1:0]    req_type_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sal_pkg::dp_cmd_t                  cmd_o,
  input  sal_pkg::dp_sts_t                  sts_i
);
  import sal_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_BACK,
    ST_BDRAIN,
    ST_FWD,
    ST_FDRAIN,
    ST_DECIDE,
    ST_WRITE,
    ST_RESP
  } state_e;

  state_e    state_q, state_d;
  res_kind_e pend_q, pend_d;
  logic      clr_resp_q, clr_resp_d;
  logic      out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d         = state_q;
    pend_d          = pend_q;
    clr_resp_d      = clr_resp_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    cmd_o           = '0;
    cmd_o.res_kind  = pend_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.col_top && sts_i.page_last) begin
          clr_resp_d = 1'b0;
          pend_d     = RES_ZERO;
          state_d    = clr_resp_q ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          if (req_type_i == REQ_CLEAR) begin
            cmd_o.page_rst = 1'b1;
            cmd_o.col_rst  = 1'b1;
            clr_resp_d     = 1'b1;
            state_d        = ST_CLEAR;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sts_i.w_zero) begin
          pend_d  = RES_ZERO;
          state_d = ST_RESP;
        end else if (sts_i.w_wide) begin
          pend_d  = RES_FULL;
          state_d = ST_RESP;
        end else begin
          cmd_o.page_rst   = 1'b1;
          cmd_o.col_set_hi = 1'b1;
          state_d          = ST_BACK;
        end
      end
      ST_BACK: begin
        cmd_o.back_issue = 1'b1;
        if (sts_i.col_zero) begin
          state_d = ST_BDRAIN;
        end
      end
      ST_BDRAIN: begin
        cmd_o.col_rst  = 1'b1;
        cmd_o.fwd_init = 1'b1;
        state_d        = ST_FWD;
      end
      ST_FWD: begin
        cmd_o.fwd_issue = 1'b1;
        if (sts_i.col_top) begin
          state_d = ST_FDRAIN;
        end
      end
      ST_FDRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts_i.fits) begin
          cmd_o.wr_init = 1'b1;
          state_d       = ST_WRITE;
        end else if (sts_i.page_last) begin
          pend_d  = RES_FULL;
          state_d = ST_RESP;
        end else begin
          cmd_o.page_inc   = 1'b1;
          cmd_o.col_set_hi = 1'b1;
          state_d          = ST_BACK;
        end
      end
      ST_WRITE: begin
        cmd_o.wr_step = 1'b1;
        if (sts_i.wr_last) begin
          pend_d  = RES_PLACED;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pend_q      <= RES_ZERO;
      clr_resp_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      clr_resp_q  <= clr_resp_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/skyline_atlas_allocator.sv =====
// Skyline atlas allocator: the ports, controller and datapath of the block
//
// Slave stream carries requests: tuser selects allocate or clear, tdata the
// rectangle width and height. Master stream returns one result per request:
// tuser is the status (set when no page has room), tdata the page, x and y.
// After reset the column memory is swept to zero, one column a cycle, over
// all PAGE_COUNT * PAGE_WIDTH columns; s_axis_tready stays low meanwhile
// and no result is produced. A clear request runs the same sweep and then
// returns one result.
// An allocate request tries pages in order. Each page tried takes a backward
// and a forward pass over its columns through the single read port of the
// column memory; a placement then updates the rectangle's columns in turn.
// The block takes one request at a time; s_axis_tready is high only when idle.
// The result sits in an output register, so the next request is taken while
// it waits; a stalled receiver holds the block only when a second result is
// ready before the first is taken.
`timescale 1ns / 1ps
`include "skyline_atlas_allocator_assert.svh"
module skyline_atlas_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // rect_width [7:0], rect_height [15:8]
  input  logic [sal_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // req_type [0]
  input  logic [sal_pkg::REQ_TYPE_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // page [5:0], x_pos [12:6], y_pos [19:13], zero fill above
  output logic [sal_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // status [0]
  output logic [sal_pkg::STATUS_W-1:0]        m_axis_tuser
);
  import sal_pkg::*;

  dp_cmd_t                 cmd;
  dp_sts_t                 sts;
  logic [PAGE_OUT_W-1:0]   res_page;
  logic [XPOS_W-1:0]       res_x;
  logic [YPOS_W-1:0]       res_y;

  sal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sal_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_width_i  (s_axis_tdata[RECT_W-1:0]),
    .req_height_i (s_axis_tdata[2*RECT_W-1:RECT_W]),
    .res_status_o (m_axis_tuser),
    .res_page_o   (res_page),
    .res_x_o      (res_x),
    .res_y_o      (res_y)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, res_y, res_x, res_page};

  `SAL_ASSERT_NEXT(a_busy_after_transfer, s_axis_tvalid && s_axis_tready,
                   !s_axis_tready, "request taken while busy")
  `SAL_ASSERT_NOW(a_full_no_position, m_axis_tvalid && (m_axis_tuser == STATUS_FULL),
                  m_axis_tdata == '0, "full result carries a position")
  `SAL_ASSERT_NOW(a_placed_fits, cmd.res_load && (cmd.res_kind == RES_PLACED),
                  sts.fits, "placement does not fit the page")
  `SAL_ASSERT_NOW(a_write_only_after_fit, cmd.wr_step, sts.fits,
                  "column update without a fitting window")

endmodule
